>>> hw/rtl/kps_pkg.sv
// Shared types, constants and helpers of the k-mer projection signature unit
`timescale 1ns / 1ps
`default_nettype none

package kps_pkg;

   // item kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_BASE = 1'b1;

   // fixed field widths
   localparam int INDEX_W = 8;
   localparam int MASK_W  = 32;
   localparam int CHAR_W  = 8;
   localparam int SIG_W   = 32;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // base codes
   localparam logic [1:0] BASE_A = 2'd0;
   localparam logic [1:0] BASE_C = 2'd1;
   localparam logic [1:0] BASE_G = 2'd2;
   localparam logic [1:0] BASE_T = 2'd3;

   // raw characters that map to a non-zero code
   localparam logic [CHAR_W-1:0] CHAR_C_UC  = 8'h43;
   localparam logic [CHAR_W-1:0] CHAR_C_LC  = 8'h63;
   localparam logic [CHAR_W-1:0] CHAR_C_NUM = 8'h01;
   localparam logic [CHAR_W-1:0] CHAR_G_UC  = 8'h47;
   localparam logic [CHAR_W-1:0] CHAR_G_LC  = 8'h67;
   localparam logic [CHAR_W-1:0] CHAR_G_NUM = 8'h02;
   localparam logic [CHAR_W-1:0] CHAR_T_UC  = 8'h54;
   localparam logic [CHAR_W-1:0] CHAR_T_LC  = 8'h74;
   localparam logic [CHAR_W-1:0] CHAR_T_NUM = 8'h03;

   // classified operation handed from front to back
   typedef struct packed {
      logic               is_load;
      logic [INDEX_W-1:0] index;
      logic [MASK_W-1:0]  plus_mask;
      logic [MASK_W-1:0]  minus_mask;
      logic               apply;
      logic               last;
   } kps_op_type;

   function automatic logic [1:0] kps_base_code(input logic [CHAR_W-1:0] ch);
      logic [1:0] code;
      case (ch) inside
         CHAR_C_UC, CHAR_C_LC, CHAR_C_NUM: code = BASE_C;
         CHAR_G_UC, CHAR_G_LC, CHAR_G_NUM: code = BASE_G;
         CHAR_T_UC, CHAR_T_LC, CHAR_T_NUM: code = BASE_T;
         default:                          code = BASE_A;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/kps_req_if.sv
// Input channel of the k-mer projection signature unit
`timescale 1ns / 1ps
`default_nettype none

interface kps_req_if
   import kps_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               kind;
   logic [INDEX_W-1:0] entry_index;
   logic [MASK_W-1:0]  plus_mask;
   logic [MASK_W-1:0]  minus_mask;
   logic [CHAR_W-1:0]  base_char;
   logic               last;

   modport source (
      output valid, kind, entry_index, plus_mask, minus_mask, base_char, last,
      input  ready
   );
   modport sink (
      input  valid, kind, entry_index, plus_mask, minus_mask, base_char, last,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/kps_rsp_if.sv
// Result channel of the k-mer projection signature unit
`timescale 1ns / 1ps
`default_nettype none

interface kps_rsp_if
   import kps_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [SIG_W-1:0] signature;

   modport source (output valid, signature, input ready);
   modport sink   (input valid, signature, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/kmer_projection_signature_unit.sv
// Top level of the k-mer projection signature unit
`timescale 1ns / 1ps
`default_nettype none

// Takes one beat per clock cycle, table loads and bases alike, as long as the
// result side keeps up. The front end tracks the k-mer window and hands each
// beat through a four-entry queue to the back end, which reads the 256-entry
// projection table through its single port (registered read) and then updates
// the counters from the registered data unless a finishing beat stalls; a
// signature is registered behind the queue and the table read and waits in an
// output register. A load takes effect before any later base reads the same
// entry. Table entries read before being loaded return undefined data.
module kmer_projection_signature_unit
   import kps_pkg::*;
#(
   parameter int KMER_LEN  = 4,
   parameter int SIG_BITS  = 32,
   parameter int ACC_WIDTH = 16
) (
   input  wire        clock,
   input  wire        reset,
   kps_req_if.sink    req_bus,
   kps_rsp_if.source  rsp_bus
);

   logic       front_valid, front_ready;
   kps_op_type front_op;
   logic       back_valid, back_ready;
   kps_op_type back_op;

   kps_front #(
      .KMER_LEN (KMER_LEN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .op_valid (front_valid),
      .op       (front_op),
      .op_ready (front_ready)
   );

   kps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_op     (front_op),
      .in_ready  (front_ready),
      .out_valid (back_valid),
      .out_op    (back_op),
      .out_ready (back_ready)
   );

   kps_back #(
      .SIG_BITS  (SIG_BITS),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (back_valid),
      .op       (back_op),
      .op_ready (back_ready),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

>>> hw/rtl/kps_front.sv
// Front end: accepts beats, tracks the k-mer window and classifies each beat
`timescale 1ns / 1ps
`default_nettype none

module kps_front
   import kps_pkg::*;
#(
   parameter int KMER_LEN = 4
) (
   input  wire         clock,
   input  wire         reset,
   kps_req_if.sink     req_bus,
   output logic        op_valid,
   output kps_op_type  op,
   input  wire         op_ready
);

   localparam int HIST_W = 2 * KMER_LEN;
   localparam int SEEN_W = $clog2(KMER_LEN + 1);

   logic [HIST_W-1:0]         history_ff, history_in;
   logic [SEEN_W-1:0]         seen_ff, seen_in;
   logic [1:0]                code;
   logic [HIST_W-1:0]         hist_shift;
   logic [HIST_W+INDEX_W-1:0] hist_ext;
   logic                      accept;

   assign req_bus.ready = op_ready;
   assign op_valid      = req_bus.valid;
   assign accept        = req_bus.valid && op_ready;

   // window update and classification
   always_comb begin
      code       = kps_base_code(req_bus.base_char);
      hist_shift = (history_ff << 2) | HIST_W'(code);
      hist_ext   = {{INDEX_W{1'b0}}, hist_shift};
      history_in = history_ff;
      seen_in    = seen_ff;
      if (accept && req_bus.kind == KIND_BASE) begin
         if (req_bus.last) begin
            history_in = '0;
            seen_in    = '0;
         end else begin
            history_in = hist_shift;
            if (seen_ff < SEEN_W'(KMER_LEN)) seen_in = seen_ff + SEEN_W'(1);
         end
      end

      op.is_load    = (req_bus.kind == KIND_LOAD);
      op.index      = op.is_load ? req_bus.entry_index : hist_ext[INDEX_W-1:0];
      op.plus_mask  = req_bus.plus_mask;
      op.minus_mask = req_bus.minus_mask;
      op.apply      = (seen_ff >= SEEN_W'(KMER_LEN - 1));
      op.last       = req_bus.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
         seen_ff    <= '0;
      end else begin
         history_ff <= history_in;
         seen_ff    <= seen_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/kps_queue.sv
// Short FIFO of classified operations between front and back
`timescale 1ns / 1ps
`default_nettype none

module kps_queue
   import kps_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         in_valid,
   input  kps_op_type  in_op,
   output logic        in_ready,
   output logic        out_valid,
   output kps_op_type  out_op,
   input  wire         out_ready
);

   kps_op_type          entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0] count_ff, count_in;
   logic                push, pop;

   assign in_ready  = (count_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_op    = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_ff + QUEUE_AW'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_ff + QUEUE_AW'(1);
      if (push && !pop)      count_in = count_ff + QUEUE_CW'(1);
      else if (pop && !push) count_in = count_ff - QUEUE_CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= in_op;
   end

endmodule

`default_nettype wire

>>> hw/rtl/kps_back.sv
// Back end: projection table, accumulator update and signature output
`timescale 1ns / 1ps
`default_nettype none

module kps_back
   import kps_pkg::*;
#(
   parameter int SIG_BITS  = 32,
   parameter int ACC_WIDTH = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         op_valid,
   input  kps_op_type  op,
   output logic        op_ready,
   kps_rsp_if.source   rsp_bus
);

   localparam int TABLE_DEPTH = 1 << INDEX_W;
   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   logic [2*MASK_W-1:0]         table_mem [TABLE_DEPTH];
   logic [2*MASK_W-1:0]         rdata_ff;
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_apply_ff, s1_last_ff;
   logic                        s1_stall, pop, step;
   logic signed [ACC_WIDTH-1:0] acc_ff [SIG_BITS];
   logic signed [ACC_WIDTH-1:0] acc_next [SIG_BITS];
   logic signed [ACC_WIDTH-1:0] acc_in [SIG_BITS];
   logic [SIG_BITS+MASK_W-1:0]  plus_ext, minus_ext;
   logic [SIG_BITS+SIG_W-1:0]   sig_ext;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [SIG_W-1:0]            rsp_sig_ff;

   // a finishing beat waits only while the output register is full and not taken
   assign s1_stall = s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_bus.ready;
   assign op_ready = !s1_stall;
   assign pop      = op_valid && !s1_stall;
   assign step     = s1_valid_ff && !s1_stall;

   // table: loads write, bases read with registered data
   always_ff @(posedge clock) begin
      if (pop && op.is_load)  table_mem[op.index] <= {op.minus_mask, op.plus_mask};
      if (pop && !op.is_load) rdata_ff <= table_mem[op.index];
   end

   // stage one control
   assign s1_valid_in = s1_stall ? 1'b1 : (pop && !op.is_load);

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= s1_valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_apply_ff <= op.apply;
         s1_last_ff  <= op.last;
      end
   end

   // saturating per-bit counters
   always_comb begin
      plus_ext  = {{SIG_BITS{1'b0}}, rdata_ff[MASK_W-1:0]};
      minus_ext = {{SIG_BITS{1'b0}}, rdata_ff[2*MASK_W-1:MASK_W]};
      sig_ext   = '0;
      for (int i = 0; i < SIG_BITS; i++) begin
         acc_next[i] = acc_ff[i];
         if (s1_apply_ff) begin
            if (plus_ext[i] && !minus_ext[i] && acc_ff[i] != ACC_MAX)
               acc_next[i] = acc_ff[i] + ACC_WIDTH'(1);
            else if (minus_ext[i] && !plus_ext[i] && acc_ff[i] != ACC_MIN)
               acc_next[i] = acc_ff[i] - ACC_WIDTH'(1);
         end
         sig_ext[i] = !acc_next[i][ACC_WIDTH-1];
         if (!step)           acc_in[i] = acc_ff[i];
         else if (s1_last_ff) acc_in[i] = '0;
         else                 acc_in[i] = acc_next[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SIG_BITS; i++) acc_ff[i] <= '0;
      end else begin
         for (int i = 0; i < SIG_BITS; i++) acc_ff[i] <= acc_in[i];
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step && s1_last_ff)  rsp_valid_in = 1'b1;
      else if (rsp_bus.ready)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (step && s1_last_ff) rsp_sig_ff <= sig_ext[SIG_W-1:0];
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.signature = rsp_sig_ff;

endmodule

`default_nettype wire
